// ===== rtl/gradient_palette_lookup_core_macros.svh =====
// Assertion macros shared by the palette lookup RTL.
`ifndef GRADIENT_PALETTE_LOOKUP_CORE_MACROS_SVH
`define GRADIENT_PALETTE_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpl_pkg.sv =====
// Package: constants, types and register codes of the palette lookup.
`default_nettype none

package gpl_pkg;

   localparam int MAX_STOPS  = 8;
   localparam int REG_STOPS  = 8;
   localparam int NUM_PAIRS  = 4;
   localparam int STOP_W     = 32;
   localparam int CNT_REG_W  = 4;
   localparam int CNT_W      = $clog2(MAX_STOPS + 1);
   localparam int NUM_SEGS   = MAX_STOPS - 1;
   localparam int NUM_CHAN   = 3;
   localparam int NUM_STAGES = 5;

   localparam int CH_HUE = 0;
   localparam int CH_SAT = 1;
   localparam int CH_VAL = 2;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_A     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_B     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_C     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_D     = CSR_IDX_W'(4);

   localparam logic [CNT_REG_W-1:0]  STOP_COUNT_RST = CNT_REG_W'(2);
   localparam logic [CSR_DATA_W-1:0] PAIR_A_RST     = 64'hFFFF_FFFF_FFFF_FF00;
   localparam logic [CSR_DATA_W-1:0] PAIR_RST       = '0;

   localparam logic [7:0] CHAN_MAX = 8'd255;
   localparam logic [7:0] CHAN_MIN = 8'd0;

   // One palette stop, position in the low byte.
   typedef struct packed {
      logic [7:0] val;
      logic [7:0] sat;
      logic [7:0] hue;
      logic [7:0] pos;
   } stop_type;

   typedef stop_type [MAX_STOPS-1:0] stop_vec_type;

   typedef logic [NUM_SEGS-1:0] seg_sel_type;

   // Operands of one channel blend, span already made non-negative.
   typedef struct packed {
      logic [7:0]        a;
      logic signed [8:0] diff;
      logic [7:0]        d;
      logic [7:0]        den;
      logic              zero;
   } blend_op_type;

   typedef blend_op_type [NUM_CHAN-1:0] blend_op_vec_type;

   // Per-stage load enables.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_en_type;

endpackage

`default_nettype wire

// ===== rtl/gpl_ifs.sv =====
// Interfaces: request, response and register write channels.
`default_nettype none

interface gpl_req_if
   import gpl_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] hue_in;

   modport source (output valid, output hue_in, input ready);
   modport sink   (input valid, input hue_in, output ready);
endinterface

interface gpl_rsp_if
   import gpl_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] out_hue;
   logic [7:0] out_sat;
   logic [7:0] out_val;

   modport source (output valid, output out_hue, output out_sat, output out_val,
                   input ready);
   modport sink   (input valid, input out_hue, input out_sat, input out_val,
                   output ready);
endinterface

interface gpl_csr_if
   import gpl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gpl_seg_search.sv =====
// Stage 1: segment search over the stop positions.
`default_nettype none

module gpl_seg_search
   import gpl_pkg::*;
(
   input  logic                 clock,
   input  pipe_en_type          en,
   input  logic [7:0]           hue_in,
   input  logic [CNT_REG_W-1:0] stop_count,
   input  stop_vec_type         stops,
   output logic [7:0]           hue_ff,
   output seg_sel_type          seg_sel_ff
);

   logic [CNT_W-1:0] count_eff;
   seg_sel_type      hit;
   seg_sel_type      first_hit;
   seg_sel_type      seg_sel_in;
   logic             seen;

   always_comb begin
      priority if (stop_count < CNT_REG_W'(2)) begin
         count_eff = CNT_W'(2);
      end else if (int'(stop_count) > MAX_STOPS) begin
         count_eff = CNT_W'(MAX_STOPS);
      end else begin
         count_eff = CNT_W'(stop_count);
      end
   end

   // first segment whose upper stop sits at or above the index
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         hit[i]       = ((i + 1) < int'(count_eff)) && (stops[i + 1].pos >= hue_in);
         first_hit[i] = hit[i] && !seen;
         seen         = seen | hit[i];
      end
      seg_sel_in = seen ? first_hit : seg_sel_type'(1);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         hue_ff     <= hue_in;
         seg_sel_ff <= seg_sel_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gpl_stop_fetch.sv =====
// Stage 2: stop pair select and blend operand set-up.
`default_nettype none

module gpl_stop_fetch
   import gpl_pkg::*;
(
   input  logic             clock,
   input  pipe_en_type      en,
   input  logic [7:0]       hue,
   input  seg_sel_type      seg_sel,
   input  stop_vec_type     stops,
   output blend_op_vec_type ops_ff
);

   stop_type                      s_lo;
   stop_type                      s_hi;
   logic signed [8:0]             span;
   logic                          neg;
   logic [7:0]                    span_abs;
   logic [7:0]                    hue_off;
   logic [NUM_CHAN-1:0][7:0]      a_v;
   logic [NUM_CHAN-1:0][7:0]      b_v;
   blend_op_vec_type              ops_in;

   always_comb begin
      s_lo = '0;
      s_hi = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (seg_sel[i]) begin
            s_lo = s_lo | stops[i];
            s_hi = s_hi | stops[i + 1];
         end
      end
   end

   always_comb begin
      span     = $signed({1'b0, s_hi.pos}) - $signed({1'b0, s_lo.pos});
      neg      = span[8];
      span_abs = neg ? 8'(-span) : 8'(span);
      hue_off  = (hue >= s_lo.pos) ? (hue - s_lo.pos) : (s_lo.pos - hue);

      a_v[CH_HUE] = s_lo.hue;
      a_v[CH_SAT] = s_lo.sat;
      a_v[CH_VAL] = s_lo.val;
      b_v[CH_HUE] = s_hi.hue;
      b_v[CH_SAT] = s_hi.sat;
      b_v[CH_VAL] = s_hi.val;

      // a negative span flips the sign of both span and step
      for (int c = 0; c < NUM_CHAN; c++) begin
         ops_in[c].a    = a_v[c];
         ops_in[c].diff = neg ? ($signed({1'b0, a_v[c]}) - $signed({1'b0, b_v[c]}))
                              : ($signed({1'b0, b_v[c]}) - $signed({1'b0, a_v[c]}));
         ops_in[c].d    = hue_off;
         ops_in[c].den  = span_abs;
         ops_in[c].zero = (span_abs == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         ops_ff <= ops_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gpl_chan_blend.sv =====
// Stages 3 to 5: numerator product, split restoring divide, saturation.
`default_nettype none

module gpl_chan_blend
   import gpl_pkg::*;
(
   input  logic         clock,
   input  pipe_en_type  en,
   input  blend_op_type op,
   output logic [7:0]   result_ff
);

   // stage 3
   logic signed [17:0] prod_base;
   logic signed [17:0] prod_step;
   logic signed [18:0] num_in;
   logic signed [18:0] num_ff;
   logic [7:0]         a3_ff;
   logic [7:0]         den3_ff;
   logic               zero3_ff;

   // stage 4
   logic               sat_lo_in;
   logic               sat_hi_in;
   logic [15:0]        rem_hi;
   logic [15:0]        trial_hi;
   logic [3:0]         q_hi_in;
   logic [11:0]        rem4_ff;
   logic [3:0]         q_hi_ff;
   logic               sat_lo_ff;
   logic               sat_hi_ff;
   logic [7:0]         a4_ff;
   logic [7:0]         den4_ff;
   logic               zero4_ff;

   // stage 5
   logic [11:0]        rem_lo;
   logic [11:0]        trial_lo;
   logic [3:0]         q_lo;
   logic [7:0]         result_in;

   always_comb begin
      prod_base = $signed({1'b0, op.a}) * $signed({1'b0, op.den});
      prod_step = $signed({1'b0, op.d}) * $signed(op.diff);
      num_in    = 19'(prod_base) + 19'(prod_step);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         num_ff   <= num_in;
         a3_ff    <= op.a;
         den3_ff  <= op.den;
         zero3_ff <= op.zero;
      end
   end

   // upper four quotient bits
   always_comb begin
      sat_lo_in = num_ff[18];
      sat_hi_in = !num_ff[18] && (num_ff[17:0] >= {2'b00, den3_ff, 8'h00});
      rem_hi    = num_ff[15:0];
      q_hi_in   = '0;
      trial_hi  = '0;
      for (int k = 3; k >= 0; k--) begin
         trial_hi = 16'(den3_ff) << (k + 4);
         if (rem_hi >= trial_hi) begin
            rem_hi     = rem_hi - trial_hi;
            q_hi_in[k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         rem4_ff   <= rem_hi[11:0];
         q_hi_ff   <= q_hi_in;
         sat_lo_ff <= sat_lo_in;
         sat_hi_ff <= sat_hi_in;
         a4_ff     <= a3_ff;
         den4_ff   <= den3_ff;
         zero4_ff  <= zero3_ff;
      end
   end

   // lower four quotient bits, then pick the result
   always_comb begin
      rem_lo   = rem4_ff;
      q_lo     = '0;
      trial_lo = '0;
      for (int k = 3; k >= 0; k--) begin
         trial_lo = 12'(den4_ff) << k;
         if (rem_lo >= trial_lo) begin
            rem_lo  = rem_lo - trial_lo;
            q_lo[k] = 1'b1;
         end
      end
      priority if (zero4_ff) begin
         result_in = a4_ff;
      end else if (sat_lo_ff) begin
         result_in = CHAN_MIN;
      end else if (sat_hi_ff) begin
         result_in = CHAN_MAX;
      end else begin
         result_in = {q_hi_ff, q_lo};
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gradient_palette_lookup_core.sv =====
// Top level: palette registers, pipeline control and lookup stages.
// Each accepted item passes through every stage in turn; the last stage drives the response channel.
// Throughput: one item per cycle; a stalled response holds each full stage whose
// successors are all full, and empty stages keep filling so bubbles close up.
// Reset: synchronous, active high; clears all stage valid bits and restores
// the palette to two stops, position 0 to 255, every channel 255 at both.
`default_nettype none
`include "gradient_palette_lookup_core_macros.svh"

module gradient_palette_lookup_core
   import gpl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   gpl_req_if.sink      req_chan,
   gpl_rsp_if.source    rsp_chan,
   gpl_csr_if.sink      csr_chan
);

   // Palette registers
   logic [CNT_REG_W-1:0]                  stop_count_ff;
   logic [CNT_REG_W-1:0]                  stop_count_in;
   logic [NUM_PAIRS-1:0][CSR_DATA_W-1:0]  pairs_ff;
   logic [NUM_PAIRS-1:0][CSR_DATA_W-1:0]  pairs_in;
   stop_vec_type                          stops;

   // Pipeline control: one valid bit per stage, stage 5 is the response
   logic [NUM_STAGES-1:0]                 valid_ff;
   logic [NUM_STAGES-1:0]                 valid_in;
   pipe_en_type                           en;

   // Datapath between stages
   logic [7:0]                            hue1;
   seg_sel_type                           seg_sel1;
   blend_op_vec_type                      ops2;
   logic [NUM_CHAN-1:0][7:0]              chan_res;

   // Register writes are always taken; software writes only while idle, which the block does not enforce.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      stop_count_in = stop_count_ff;
      pairs_in      = pairs_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            REG_STOP_COUNT: stop_count_in = csr_chan.data[CNT_REG_W-1:0];
            REG_PAIR_A:     pairs_in[0]   = csr_chan.data;
            REG_PAIR_B:     pairs_in[1]   = csr_chan.data;
            REG_PAIR_C:     pairs_in[2]   = csr_chan.data;
            REG_PAIR_D:     pairs_in[3]   = csr_chan.data;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= STOP_COUNT_RST;
         pairs_ff[0]   <= PAIR_A_RST;
         pairs_ff[1]   <= PAIR_RST;
         pairs_ff[2]   <= PAIR_RST;
         pairs_ff[3]   <= PAIR_RST;
      end else begin
         stop_count_ff <= stop_count_in;
         pairs_ff      <= pairs_in;
      end
   end

   // Unpack the stop registers; stops with no register read as zero.
   for (genvar k = 0; k < MAX_STOPS; k++) begin : g_stop
      if (k < REG_STOPS) begin : g_reg
         assign stops[k] = stop_type'(pairs_ff[k >> 1][(k & 1) * STOP_W +: STOP_W]);
      end else begin : g_none
         assign stops[k] = '0;
      end
   end

   // A stage loads when it is empty or its successor is loading.
   always_comb begin
      en.s5 = !valid_ff[4] || rsp_chan.ready;
      en.s4 = !valid_ff[3] || en.s5;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;
   end

   assign req_chan.ready = en.s1;

   // Advance valid bits with the data; hold them where the stage is stalled.
   always_comb begin
      valid_in[0] = en.s1 ? req_chan.valid : valid_ff[0];
      valid_in[1] = en.s2 ? valid_ff[0]    : valid_ff[1];
      valid_in[2] = en.s3 ? valid_ff[1]    : valid_ff[2];
      valid_in[3] = en.s4 ? valid_ff[2]    : valid_ff[3];
      valid_in[4] = en.s5 ? valid_ff[3]    : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: find the segment
   gpl_seg_search u_seg_search (
      .clock      (clock),
      .en         (en),
      .hue_in     (req_chan.hue_in),
      .stop_count (stop_count_ff),
      .stops      (stops),
      .hue_ff     (hue1),
      .seg_sel_ff (seg_sel1)
   );

   // Stage 2: pick the two stops and set up blend operands
   gpl_stop_fetch u_stop_fetch (
      .clock   (clock),
      .en      (en),
      .hue     (hue1),
      .seg_sel (seg_sel1),
      .stops   (stops),
      .ops_ff  (ops2)
   );

   // Stages 3 to 5: one blend lane per colour channel
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      gpl_chan_blend u_chan_blend (
         .clock     (clock),
         .en        (en),
         .op        (ops2[c]),
         .result_ff (chan_res[c])
      );
   end

   // Stage 5 registers are the response register.
   assign rsp_chan.valid   = valid_ff[4];
   assign rsp_chan.out_hue = chan_res[CH_HUE];
   assign rsp_chan.out_sat = chan_res[CH_SAT];
   assign rsp_chan.out_val = chan_res[CH_VAL];

   // Checks
   `GPL_ASSERT_NXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready,
                   valid_ff[0], "accepted item did not enter stage 1")
   `GPL_ASSERT_IMP(a_full_blocks, clock, reset, (&valid_ff) && !rsp_chan.ready,
                   !req_chan.ready, "full pipeline accepted an item under stall")
   `GPL_ASSERT_IMP(a_seg_onehot, clock, reset, valid_ff[0], $onehot(seg_sel1),
                   "segment select not one-hot")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the gradient palette lookup core.
`timescale 1ns / 100ps

module tb;
   import gpl_pkg::*;

   localparam int MAX_IDLE     = 11;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_SETS  = 10;
   localparam int SET_ITEMS    = 75;

   // One HSV colour as it leaves the block.
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } colour_type;

   // Palette register copy, colour predictor and queue of colours still owed by the block.
   class palette_scoreboard;
      logic [CNT_REG_W-1:0]  stop_count;
      logic [CSR_DATA_W-1:0] pairs [NUM_PAIRS];
      colour_type            pending_colours [$];
      int                    lookups_checked;
      int                    mismatches;

      function new();
         stop_count = STOP_COUNT_RST;
         pairs[0]   = PAIR_A_RST;
         for (int p = 1; p < NUM_PAIRS; p++) pairs[p] = PAIR_RST;
         lookups_checked = 0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_STOP_COUNT: stop_count = value[CNT_REG_W-1:0];
            REG_PAIR_A:     pairs[0] = value;
            REG_PAIR_B:     pairs[1] = value;
            REG_PAIR_C:     pairs[2] = value;
            REG_PAIR_D:     pairs[3] = value;
            default: ;
         endcase
      endfunction

      function stop_type stop_at(int k);
         logic [CSR_DATA_W-1:0] pair;
         pair = pairs[k / 2];
         return (k % 2) ? pair[63:32] : pair[31:0];
      endfunction

      // Exact a + d*(b-a)/span, truncated toward zero and clamped to a byte.
      function logic [7:0] blend_chan(int a, int b, int d, int span);
         int num;
         int q;
         if (span == 0) return a[7:0];
         num = a * span + d * (b - a);
         if (span < 0) begin
            span = -span;
            num  = -num;
         end
         q = num / span;
         if (q < int'(CHAN_MIN)) return CHAN_MIN;
         if (q > int'(CHAN_MAX)) return CHAN_MAX;
         return q[7:0];
      endfunction

      function colour_type lookup_colour(logic [7:0] hue);
         int         count;
         int         seg;
         int         span;
         int         d;
         bit         found;
         stop_type   s1;
         stop_type   s2;
         colour_type c;
         count = int'(stop_count);
         if (count < 2) count = 2;
         if (count > MAX_STOPS) count = MAX_STOPS;
         seg   = 0;
         found = 1'b0;
         for (int i = 0; i + 1 < count; i++) begin
            s2 = stop_at(i + 1);
            if (!found && s2.pos >= hue) begin
               seg   = i;
               found = 1'b1;
            end
         end
         s1   = stop_at(seg);
         s2   = stop_at(seg + 1);
         span = int'(s2.pos) - int'(s1.pos);
         d    = int'(hue) - int'(s1.pos);
         if (d < 0) d = -d;
         c.hue = blend_chan(s1.hue, s2.hue, d, span);
         c.sat = blend_chan(s1.sat, s2.sat, d, span);
         c.val = blend_chan(s1.val, s2.val, d, span);
         return c;
      endfunction

      function void note_lookup(logic [7:0] hue);
         pending_colours.push_back(lookup_colour(hue));
      endfunction

      function void check_colour(colour_type got);
         colour_type want;
         if (pending_colours.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR %0t: unexpected colour h=%0d s=%0d v=%0d", $time,
                        got.hue, got.sat, got.val);
            return;
         end
         want = pending_colours.pop_front();
         lookups_checked++;
         if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR %0t: colour h/s/v expected %0d/%0d/%0d got %0d/%0d/%0d",
                        $time, want.hue, want.sat, want.val, got.hue, got.sat, got.val);
         end
      endfunction

      function int outstanding();
         return pending_colours.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpl_req_if req_if ();
   gpl_rsp_if rsp_if ();
   gpl_csr_if csr_if ();

   gradient_palette_lookup_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   palette_scoreboard palette = new();

   bit req_calm      = 1'b0;
   bit rsp_calm      = 1'b0;
   int settings_used = 1;   // the reset palette counts as the first

   always #6 clock = ~clock;

   // Hard stop: far beyond the slowest legal run of this stimulus.
   initial begin
      #4_000_000;
      $display("Timeout: lookups still outstanding = %0d", palette.outstanding());
      $display("Verification failed");
      $finish;
   end

   // Response side: draw a stall per item, with calm stretches where ready stays high.
   initial begin
      int         stall;
      colour_type got;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         // Sampled at the edge, so these are the values the block presented.
         got.hue = rsp_if.out_hue;
         got.sat = rsp_if.out_sat;
         got.val = rsp_if.out_val;
         palette.check_colour(got);
      end
   end

   // Offer one hue; hold valid across back-to-back items rather than dropping it.
   task automatic send_lookup(input logic [7:0] hue);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.hue_in <= hue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      palette.note_lookup(hue);
   endtask

   // Drop valid, wait for every owed colour, then let the pipeline run dry.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (palette.outstanding() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   // Write every register in turn; call only while the block is idle.
   task automatic program_palette(input logic [CSR_DATA_W-1:0] count_word,
                                  input logic [CSR_DATA_W-1:0] pa, pb, pc, pd);
      logic [CSR_IDX_W-1:0]  codes  [NUM_PAIRS+1];
      logic [CSR_DATA_W-1:0] values [NUM_PAIRS+1];
      codes  = '{REG_STOP_COUNT, REG_PAIR_A, REG_PAIR_B, REG_PAIR_C, REG_PAIR_D};
      values = '{count_word, pa, pb, pc, pd};
      for (int r = 0; r <= NUM_PAIRS; r++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= codes[r];
         csr_if.data  <= values[r];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         palette.write_reg(codes[r], values[r]);
      end
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // One random palette followed by a burst of lookups against it.
   task automatic run_random_set(input int set_no);
      logic [CSR_DATA_W-1:0] pairs [NUM_PAIRS];
      logic [CSR_DATA_W-1:0] count_word;
      stop_type              s;
      int                    pos;
      int                    shape;
      int                    k;
      logic [7:0]            hue;
      shape = $urandom_range(0, 9);
      // Mostly an ordered palette; sometimes the count is out of range.
      count_word = {$urandom, $urandom};
      count_word[CNT_REG_W-1:0] = (shape == 0) ? CNT_REG_W'($urandom_range(0, 15))
                                               : CNT_REG_W'($urandom_range(2, MAX_STOPS));
      pos = (shape < 3) ? 0 : $urandom_range(0, 40);
      for (int j = 0; j < MAX_STOPS; j++) begin
         s     = $urandom;
         s.pos = pos[7:0];
         pairs[j / 2][32 * (j % 2) +: 32] = s;
         pos = pos + $urandom_range(0, 70);
         if (pos > 255) pos = 255;
      end
      // Fully random words: stops out of order and negative spans.
      if (shape == 1)
         for (int p = 0; p < NUM_PAIRS; p++) pairs[p] = {$urandom, $urandom};
      // Extremes of every register first.
      if (set_no == 0) begin
         count_word = '1;
         for (int p = 0; p < NUM_PAIRS; p++) pairs[p] = '1;
      end else if (set_no == 1) begin
         count_word = '0;
         for (int p = 0; p < NUM_PAIRS; p++) pairs[p] = '0;
      end
      program_palette(count_word, pairs[0], pairs[1], pairs[2], pairs[3]);
      for (int n = 0; n < SET_ITEMS; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            hue = 8'($urandom);
         end else begin
            // Aim at a stop position, one either side, to hit segment boundaries.
            k   = $urandom_range(0, MAX_STOPS - 1);
            s   = pairs[k / 2][32 * (k % 2) +: 32];
            hue = s.pos + 8'($urandom_range(0, 2)) - 8'd1;
         end
         send_lookup(hue);
      end
      settle();
   endtask

   initial begin
      req_if.valid  <= 1'b0;
      req_if.hue_in <= '0;
      csr_if.valid  <= 1'b0;
      csr_if.index  <= REG_STOP_COUNT;
      csr_if.data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset palette: every channel at 255 over the full index range.
      send_lookup(8'd0); send_lookup(8'd255); send_lookup(8'd128);
      settle();

      // Zero span on the first segment: low indexes and the overflow both give colour one.
      program_palette(64'd3, 64'h3C00C828_80FA0A28, 64'h00000000_FFFF00C8, '0, '0);
      send_lookup(8'd0);   send_lookup(8'd40);  send_lookup(8'd41);
      send_lookup(8'd120); send_lookup(8'd200); send_lookup(8'd255);
      settle();

      // Index past the last stop: segment zero extrapolated and clamped at both ends.
      program_palette(64'd2, 64'hFF00C864_80FF0000, '0, '0, '0);
      send_lookup(8'd0); send_lookup(8'd100); send_lookup(8'd101); send_lookup(8'd255);
      settle();

      // Stops out of order: a negative span on the first segment.
      program_palette(64'd3, 64'h0000FF32_FF6400C8, 64'h00000000_1E1E1EFF, '0, '0);
      send_lookup(8'd0); send_lookup(8'd50); send_lookup(8'd51); send_lookup(8'd255);
      settle();

      // Count below range clamps up to two stops.
      program_palette(64'd0, 64'h0000FF32_FF6400C8, 64'h00000000_1E1E1EFF, '0, '0);
      send_lookup(8'd255);
      settle();

      // Count above range clamps down to all eight stops.
      program_palette(64'd15, 64'h11223340_AABBCC00, 64'h556677C0_33445580,
                      64'h99AABBF0_778899E0, 64'hDDEEFFFF_CCDDEEF8);
      send_lookup(8'd0); send_lookup(8'd250); send_lookup(8'd255);
      settle();

      // Count of one, same eight-stop palette.
      program_palette(64'd1, 64'h11223340_AABBCC00, 64'h556677C0_33445580,
                      64'h99AABBF0_778899E0, 64'hDDEEFFFF_CCDDEEF8);
      send_lookup(8'd255);
      settle();

      for (int set_no = 0; set_no < RANDOM_SETS; set_no++) run_random_set(set_no);

      $display("Summary: %0d colour lookups checked across %0d palette settings",
               palette.lookups_checked, settings_used);
      $display("Summary: %0d mismatching or unexpected colours", palette.mismatches);
      if (palette.mismatches == 0 && palette.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
